>>> hdl/set_assoc_cache_lru_sim_assert.svh
// Assertion macros for the LRU cache simulator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH

// Check under reset gating.
`define SACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define SACL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/sacl_pkg.sv
// Shared types and constants for the LRU cache simulator.
// No dependencies.
package sacl_pkg;

  localparam int MaxSetsDef   = 256;
  localparam int MaxWaysDef   = 8;
  localparam int AddrWidthDef = 64;
  localparam int WayIdxW      = 4;
  localparam int RankW        = 3;
  localparam logic [RankW-1:0] RankMax = 3'd7;
  localparam logic [3:0] SetBitsMax = 4'd8;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_STORE,
    CMD_MODIFY,
    CMD_IFETCH
  } cmd_e;

  typedef enum logic [1:0] {
    OC_HIT,
    OC_MISS,
    OC_EVICT
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_SET_BITS,
    CFG_BLOCK_BITS,
    CFG_WAYS
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOOK
  } state_e;

  typedef struct packed {
    logic               hit_found;
    logic [WayIdxW-1:0] hit_way;
    logic [RankW-1:0]   hit_rank;
    logic               inv_found;
    logic [WayIdxW-1:0] inv_way;
    logic               have_best;
    logic [RankW-1:0]   best_rank;
    logic [WayIdxW-1:0] best_way;
  } chain_t;

  typedef struct packed {
    logic [WayIdxW-1:0] way;
    logic               was_valid;
    logic [RankW-1:0]   old_rank;
  } touch_t;

endpackage

>>> hdl/sacl_cell.sv
// One way of the current set: holds its line state, joins the victim chain
// and applies the LRU update. Depends on sacl_pkg.
module sacl_cell #(
  parameter int ADDR_WIDTH = sacl_pkg::AddrWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sacl_pkg::WayIdxW-1:0] way_id_i,
  input  logic                        active_i,
  input  logic                        load_i,
  input  logic                        load_valid_i,
  input  logic [ADDR_WIDTH-1:0]       load_tag_i,
  input  logic [sacl_pkg::RankW-1:0]  load_rank_i,
  input  logic                        upd_i,
  input  logic [ADDR_WIDTH-1:0]       lookup_tag_i,
  input  sacl_pkg::chain_t            chain_i,
  output sacl_pkg::chain_t            chain_o,
  input  sacl_pkg::touch_t            touch_i,
  output logic                        valid_o,
  output logic [ADDR_WIDTH-1:0]       tag_o,
  output logic [sacl_pkg::RankW-1:0]  rank_o
);
  import sacl_pkg::*;

  logic              valid_q, valid_d;
  logic [ADDR_WIDTH-1:0] tag_q, tag_d;
  logic [RankW-1:0]  rank_q, rank_d;
  logic              hit;

  assign hit = active_i && valid_q && (tag_q == lookup_tag_i);

  always_comb begin
    chain_o = chain_i;
    if (hit && !chain_i.hit_found) begin
      chain_o.hit_found = 1'b1;
      chain_o.hit_way   = way_id_i;
      chain_o.hit_rank  = rank_q;
    end
    if (active_i && !valid_q && !chain_i.inv_found) begin
      chain_o.inv_found = 1'b1;
      chain_o.inv_way   = way_id_i;
    end
    if (active_i && valid_q && (!chain_i.have_best || rank_q > chain_i.best_rank)) begin
      chain_o.have_best = 1'b1;
      chain_o.best_rank = rank_q;
      chain_o.best_way  = way_id_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    rank_d  = rank_q;
    if (touch_i.way == way_id_i) begin
      valid_d = 1'b1;
      tag_d   = lookup_tag_i;
      rank_d  = '0;
    end else if (active_i && valid_q && rank_q != RankMax &&
                 (!touch_i.was_valid || rank_q < touch_i.old_rank)) begin
      rank_d = rank_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= load_valid_i;
    end else if (upd_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tag_q  <= load_tag_i;
      rank_q <= load_rank_i;
    end else if (upd_i) begin
      tag_q  <= tag_d;
      rank_q <= rank_d;
    end
  end

  assign valid_o = valid_d;
  assign tag_o   = tag_d;
  assign rank_o  = rank_d;

endmodule

>>> hdl/set_assoc_cache_lru_sim.sv
// An accepted access goes through a set memory read, a row load into the way
// cells and one lookup per cycle while the output is not stalled; a modify
// takes a second lookup for its second result. No new access is taken meanwhile.
// Instruction fetches are taken while idle and give no result.
// Reset clears valid flags per set, ways, totals and config to defaults.
// Top level of the LRU cache simulator; depends on sacl_pkg, sacl_cell, assert header.
`include "set_assoc_cache_lru_sim_assert.svh"
module set_assoc_cache_lru_sim #(
  parameter int MAX_SETS   = sacl_pkg::MaxSetsDef,
  parameter int MAX_WAYS   = sacl_pkg::MaxWaysDef,
  parameter int ADDR_WIDTH = sacl_pkg::AddrWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [5:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [ADDR_WIDTH-1:0] address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            outcome_o,
  output logic                  last_o,
  output logic [31:0]           hit_total_o,
  output logic [31:0]           miss_total_o,
  output logic [31:0]           eviction_total_o
);
  import sacl_pkg::*;

  localparam int SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WayW  = 1 + ADDR_WIDTH + RankW;
  localparam int RowW  = MAX_WAYS * WayW;

  logic [3:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_q;

  state_e state_q, state_d;
  logic   rd_en, load_cells, step, last_d, pass_q;
  cmd_e   cmd_q;
  logic [SetW-1:0] set_q, set_n;
  logic [ADDR_WIDTH-1:0] tag_q, tag_n;

  logic [RowW-1:0] mem [MAX_SETS];
  logic [RowW-1:0] rd_q, wr_row;
  logic [MAX_SETS-1:0] row_valid_q;
  logic rowv_rd_q;

  logic [3:0] sb, nways;
  logic [6:0] sh;
  logic [63:0] addr64, sidx;

  chain_t links [MAX_WAYS+1];
  chain_t ce;
  touch_t touch;
  logic   hit_inc, miss_inc, evict_inc;
  outcome_e oc;

  logic [31:0] hit_q, miss_q, evict_q;
  logic        out_valid_q, last_q;
  outcome_e    outcome_q;

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 4'd4;
      block_bits_q <= 6'd4;
      ways_q       <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[3:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    sb     = (set_bits_q > SetBitsMax) ? SetBitsMax : set_bits_q;
    sh     = 7'(sb) + 7'(block_bits_q);
    addr64 = 64'(address_i);
    sidx   = (addr64 >> block_bits_q) & ((64'd1 << sb) - 64'd1);
    set_n  = SetW'(17'(sidx[7:0]) & 17'(MAX_SETS - 1));
    tag_n  = (sh >= 7'd64) ? '0 : ADDR_WIDTH'(addr64 >> sh);
    if (ways_q == 4'd0) begin
      nways = 4'd1;
    end else if (32'(ways_q) > MAX_WAYS) begin
      nways = 4'(MAX_WAYS);
    end else begin
      nways = ways_q;
    end
  end

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && cmd_e'(command_i) != CMD_IFETCH) state_d = S_READ;
      end
      S_READ: state_d = S_LOOK;
      S_LOOK: begin
        if (step && last_d) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    rd_en      = in_ready_o && in_valid_i;
    load_cells = (state_q == S_READ);
    step       = (state_q == S_LOOK) && (!out_valid_q || out_ready_i);
    last_d     = !(cmd_q == CMD_MODIFY && !pass_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        pass_q <= 1'b0;
      end else if (step) begin
        pass_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cmd_q <= cmd_e'(command_i);
      set_q <= set_n;
      tag_q <= tag_n;
    end
  end

  // set memory
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[set_n];
    if (step) mem[set_q] <= wr_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rowv_rd_q   <= 1'b0;
    end else begin
      if (rd_en) rowv_rd_q <= row_valid_q[set_n];
      if (step) row_valid_q[set_q] <= 1'b1;
    end
  end

  // way cells
  assign links[0] = '0;

  for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
    logic [WayW-1:0] rd_way;
    logic            v_o;
    logic [ADDR_WIDTH-1:0] t_o;
    logic [RankW-1:0] r_o;

    assign rd_way = rowv_rd_q ? rd_q[w*WayW +: WayW] : '0;

    sacl_cell #(
      .ADDR_WIDTH(ADDR_WIDTH)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .way_id_i    (WayIdxW'(w)),
      .active_i    (w < 32'(nways)),
      .load_i      (load_cells),
      .load_valid_i(rd_way[WayW-1]),
      .load_tag_i  (rd_way[RankW +: ADDR_WIDTH]),
      .load_rank_i (rd_way[RankW-1:0]),
      .upd_i       (step),
      .lookup_tag_i(tag_q),
      .chain_i     (links[w]),
      .chain_o     (links[w+1]),
      .touch_i     (touch),
      .valid_o     (v_o),
      .tag_o       (t_o),
      .rank_o      (r_o)
    );

    assign wr_row[w*WayW +: WayW] = {v_o, t_o, r_o};
  end

  assign ce = links[MAX_WAYS];

  always_comb begin
    touch.was_valid = ce.hit_found || !ce.inv_found;
    touch.old_rank  = ce.hit_found ? ce.hit_rank : ce.best_rank;
    if (ce.hit_found) begin
      touch.way = ce.hit_way;
      oc        = OC_HIT;
    end else if (ce.inv_found) begin
      touch.way = ce.inv_way;
      oc        = OC_MISS;
    end else begin
      touch.way = ce.best_way;
      oc        = OC_EVICT;
    end
    hit_inc   = step && ce.hit_found;
    miss_inc  = step && !ce.hit_found;
    evict_inc = step && !ce.hit_found && !ce.inv_found;
  end

  // totals and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hit_inc && hit_q != '1) hit_q <= hit_q + 32'd1;
      if (miss_inc && miss_q != '1) miss_q <= miss_q + 32'd1;
      if (evict_inc && evict_q != '1) evict_q <= evict_q + 32'd1;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      outcome_q <= oc;
      last_q    <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign last_o           = last_q;
  assign hit_total_o      = hit_q;
  assign miss_total_o     = miss_q;
  assign eviction_total_o = evict_q;

  `SACL_ASSERT_ALWAYS(a_one_kind, $countones({hit_inc, miss_inc}) <= 1, "hit and miss together")
  `SACL_ASSERT(a_evict_is_miss, evict_inc |-> miss_inc, "eviction without miss")
  `SACL_ASSERT(a_modify_second, step && !last_d |=> state_q == S_LOOK,
               "modify lost its second lookup")
  `SACL_ASSERT(a_ready_idle, in_ready_o |-> !load_cells && !step, "input taken while busy")

endmodule
